// ----- rtl/mfat_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_pkg
// Shared types and constants of the motor feedback angle tracker.
// ----------------------------------------------------------------------------
package mfat_pkg;

	localparam int CPR_DEFAULT = 8192;

	localparam int IN_W    = 56;
	localparam int OUT_W   = 120;
	localparam int TOTAL_W = 48;
	localparam int STEP_W  = 18;
	localparam int RATIO_W = 24;
	localparam int KIND_W  = 2;
	localparam int ANGLE_W = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam int QUEUE_DEPTH = 2;

	localparam int ANGLE_SCALE = 36000;

	localparam logic [RATIO_W-1:0] RATIO_ONE         = 24'd65536;
	localparam logic [RATIO_W-1:0] SMALL_RATIO_RESET = 24'd2359296;
	localparam logic [RATIO_W-1:0] LARGE_RATIO_RESET = 24'd1258502;

	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SMALL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LARGE = 2'd2;

	localparam logic [1:0] REG_KIND        = 2'd0;
	localparam logic [1:0] REG_SMALL_RATIO = 2'd1;
	localparam logic [1:0] REG_LARGE_RATIO = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [RATIO_W-1:0] small_ratio;
		logic [RATIO_W-1:0] large_ratio;
	} cfg_t;

	// one unpacked frame waiting for the angle unit
	typedef struct packed {
		logic [15:0]               position_raw;
		logic signed [15:0]        speed_rpm;
		logic [15:0]               phase_current;
		logic [7:0]                temperature;
		logic signed [TOTAL_W-1:0] pulse_total;
		logic                      track;
		logic [RATIO_W-1:0]        ratio;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MOD,
		BK_ADJ,
		BK_MUL,
		BK_DIV,
		BK_HOLD
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/mfat_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_queue
// Short register queue between the frame front end and the angle unit.
// ----------------------------------------------------------------------------
module mfat_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  mfat_pkg::entry_t wr_entry,
	output logic             full,
	input  wire              pop,
	output logic             not_empty,
	output mfat_pkg::entry_t head
);
	import mfat_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mfat_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_front
// Frame intake: unpacks the bytes, unwraps the position step and keeps the
// saturating pulse total.
// ----------------------------------------------------------------------------
module mfat_front #(
	parameter int COUNTS_PER_REV = mfat_pkg::CPR_DEFAULT
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  mfat_pkg::cfg_t           cfg,
	input  wire                      s_tvalid,
	output logic                     s_tready,
	input  wire [mfat_pkg::IN_W-1:0] s_tdata,
	input  wire                      q_full,
	output logic                     push,
	output mfat_pkg::entry_t         wr_entry
);
	import mfat_pkg::*;

	localparam int SUM_W = TOTAL_W + 1;
	localparam logic signed [STEP_W-1:0] HALF  = STEP_W'(COUNTS_PER_REV / 2);
	localparam logic signed [STEP_W-1:0] CPR_S = STEP_W'(COUNTS_PER_REV);
	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	logic [15:0]               prev_position_q;
	logic signed [TOTAL_W-1:0] count_total_q;

	logic [15:0]               pos;
	logic                      track;
	logic [RATIO_W-1:0]        ratio_sel;
	logic signed [STEP_W-1:0]  step_raw;
	logic signed [STEP_W-1:0]  step;
	logic signed [SUM_W-1:0]   sum;
	logic signed [TOTAL_W-1:0] total_sat;
	logic signed [TOTAL_W-1:0] total_next;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	assign pos   = {s_tdata[7:0], s_tdata[15:8]};
	assign track = (cfg.kind == KIND_SMALL) || (cfg.kind == KIND_LARGE);

	always_comb begin
		ratio_sel = (cfg.kind == KIND_LARGE) ? cfg.large_ratio : cfg.small_ratio;
		if (ratio_sel < RATIO_ONE) begin
			ratio_sel = RATIO_ONE;
		end
	end

	// wrap the step into half a revolution either way
	always_comb begin
		step_raw = $signed({2'b00, pos}) - $signed({2'b00, prev_position_q});
		if (step_raw > HALF) begin
			step = step_raw - CPR_S;
		end else if (step_raw < -HALF) begin
			step = step_raw + CPR_S;
		end else begin
			step = step_raw;
		end
	end

	always_comb begin
		sum = $signed({count_total_q[TOTAL_W-1], count_total_q})
			+ $signed({{(SUM_W-STEP_W){step[STEP_W-1]}}, step});
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			total_sat = sum[SUM_W-1] ? TOTAL_MIN : TOTAL_MAX;
		end else begin
			total_sat = sum[TOTAL_W-1:0];
		end
		total_next = track ? total_sat : count_total_q;
	end

	always_comb begin
		wr_entry.position_raw   = pos;
		wr_entry.speed_rpm      = $signed({s_tdata[23:16], s_tdata[31:24]});
		wr_entry.phase_current  = {s_tdata[39:32], s_tdata[47:40]};
		wr_entry.temperature    = s_tdata[55:48];
		wr_entry.pulse_total    = total_next;
		wr_entry.track          = track;
		wr_entry.ratio          = ratio_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_position_q <= '0;
			count_total_q   <= '0;
		end else if (push) begin
			prev_position_q <= pos;
			count_total_q   <= total_next;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mfat_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_back
// Angle unit: floor modulus of the total by counts times ratio, then the
// scaled quotient, both on one shift-subtract step, and the output register.
// ----------------------------------------------------------------------------
module mfat_back #(
	parameter int COUNTS_PER_REV = mfat_pkg::CPR_DEFAULT
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        q_not_empty,
	input  mfat_pkg::entry_t           head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [mfat_pkg::OUT_W-1:0] m_tdata
);
	import mfat_pkg::*;

	localparam int DW     = $clog2(COUNTS_PER_REV) + RATIO_W;
	localparam int PROD_W = DW + ANGLE_W;
	localparam int CNT_W  = $clog2(TOTAL_W);
	localparam logic [DW-1:0]     CPR_D   = DW'(COUNTS_PER_REV);
	localparam logic [PROD_W-1:0] SCALE_P = PROD_W'(ANGLE_SCALE);

	back_state_t state_q;
	back_state_t state_next;

	entry_t                cur_q;
	logic [DW-1:0]         den_q;
	logic [DW-1:0]         rem_q;
	logic [TOTAL_W-1:0]    mag_q;
	logic [ANGLE_W-1:0]    low_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	logic                  out_free;
	logic                  out_load;
	logic                  in_bit;
	logic [DW:0]           sh;
	logic [DW:0]           diff;
	logic                  ge;
	logic [DW-1:0]         next_rem;
	logic [PROD_W-1:0]     prod;
	logic [ANGLE_W-1:0]    angle;

	assign out_free = !m_tvalid_q || m_tready;

	// shared shift-subtract step
	always_comb begin
		in_bit   = (state_q == BK_MOD) ? mag_q[TOTAL_W-1] : low_q[ANGLE_W-1];
		sh       = {rem_q, in_bit};
		diff     = sh - {1'b0, den_q};
		ge       = (sh >= {1'b0, den_q});
		next_rem = ge ? diff[DW-1:0] : sh[DW-1:0];
		prod     = PROD_W'(rem_q) * SCALE_P;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_not_empty) begin
					state_next = head.track ? BK_MOD : BK_HOLD;
				end
			end
			BK_MOD: begin
				if (cnt_q == '0) begin
					state_next = BK_ADJ;
				end
			end
			BK_ADJ: state_next = BK_MUL;
			BK_MUL: state_next = BK_DIV;
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_next = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (out_free) begin
					state_next = BK_IDLE;
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == BK_IDLE) && q_not_empty;
		out_load = (state_q == BK_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				cur_q <= head;
				den_q <= CPR_D * DW'(head.ratio);
				rem_q <= '0;
				mag_q <= head.pulse_total[TOTAL_W-1] ? -head.pulse_total : head.pulse_total;
				cnt_q <= CNT_W'(TOTAL_W - 1);
			end
			BK_MOD: begin
				rem_q <= next_rem;
				mag_q <= {mag_q[TOTAL_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			BK_ADJ: begin
				// floor modulus for a negative total
				if (cur_q.pulse_total[TOTAL_W-1] && (rem_q != '0)) begin
					rem_q <= den_q - rem_q;
				end
			end
			BK_MUL: begin
				// high part is below the divisor, low part shifts in bit by bit
				rem_q <= prod[PROD_W-1:ANGLE_W];
				low_q <= prod[ANGLE_W-1:0];
				cnt_q <= CNT_W'(ANGLE_W - 1);
			end
			BK_DIV: begin
				rem_q <= next_rem;
				low_q <= {low_q[ANGLE_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign angle = cur_q.track ? low_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {angle, cur_q.pulse_total, cur_q.temperature,
				cur_q.phase_current, cur_q.speed_rpm, cur_q.position_raw};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ----- rtl/motor_feedback_angle_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker
// Unpacks motor feedback frames, unwraps the rotor position into a
// saturating multi-turn count and gives the output shaft angle.
// ----------------------------------------------------------------------------
// Path: a tracking kind goes from accept through the queue, a 48-step modulus,
//   the floor adjust, the product, a 16-step angle division and the output load; kind 0 skips to the load.
// Flow: the angle path has a single shift-subtract unit and takes a new item only
//   once the last one is in the output register; the intake takes items while the queue has room.
// Reset (arst_n low): pulse total and last position clear, kind 0, ratio
//   registers to their defaults, queue empty, no output valid.
module motor_feedback_angle_tracker #(
	parameter int COUNTS_PER_REV = mfat_pkg::CPR_DEFAULT
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [mfat_pkg::ADDR_W-1:0]  paddr,
	input  wire [mfat_pkg::DATA_W-1:0]  pwdata,
	output logic [mfat_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// pos_high, pos_low, speed_high, speed_low, current_high, current_low, temp_byte
	input  wire [mfat_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	// position_raw, speed_rpm, phase_current, temperature, pulse_total, shaft_angle
	output logic [mfat_pkg::OUT_W-1:0]  m_tdata
);
	import mfat_pkg::*;

	cfg_t   cfg_q;
	logic   wr_en;
	logic   q_full;
	logic   q_not_empty;
	logic   push;
	logic   pop;
	entry_t wr_entry;
	entry_t head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind        <= KIND_NONE;
			cfg_q.small_ratio <= SMALL_RATIO_RESET;
			cfg_q.large_ratio <= LARGE_RATIO_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_KIND:        cfg_q.kind        <= pwdata[KIND_W-1:0];
				REG_SMALL_RATIO: cfg_q.small_ratio <= pwdata[RATIO_W-1:0];
				REG_LARGE_RATIO: cfg_q.large_ratio <= pwdata[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_KIND:        prdata = DATA_W'(cfg_q.kind);
			REG_SMALL_RATIO: prdata = DATA_W'(cfg_q.small_ratio);
			REG_LARGE_RATIO: prdata = DATA_W'(cfg_q.large_ratio);
			default:         prdata = '0;
		endcase
	end

	mfat_front #(
		.COUNTS_PER_REV(COUNTS_PER_REV)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.wr_entry (wr_entry)
	);

	mfat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	mfat_back #(
		.COUNTS_PER_REV(COUNTS_PER_REV)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
`default_nettype wire

// ----- rtl/mfat_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfat_checker
// Port-level checks of the angle tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mfat_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         psel,
	input wire                         penable,
	input wire                         pwrite,
	input wire [mfat_pkg::ADDR_W-1:0]  paddr,
	input wire [mfat_pkg::DATA_W-1:0]  pwdata,
	input wire [mfat_pkg::DATA_W-1:0]  prdata,
	input wire                         pready,
	input wire                         s_tvalid,
	input wire                         s_tready,
	input wire [mfat_pkg::IN_W-1:0]    s_tdata,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire [mfat_pkg::OUT_W-1:0]   m_tdata
);
	import mfat_pkg::*;

	logic [KIND_W-1:0] kind_q;
	logic              tracking;

	// shadow of the kind register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (psel && penable && pwrite && pready && (paddr[3:2] == REG_KIND)) begin
			kind_q <= pwdata[KIND_W-1:0];
		end
	end

	assign tracking = (kind_q == KIND_SMALL) || (kind_q == KIND_LARGE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[119:104] < 16'd36000))
		else $error("shaft angle out of range");

	a_angle_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !tracking |-> (m_tdata[119:104] == 16'd0))
		else $error("angle nonzero without turn tracking");

	a_kind_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[3:2] == REG_KIND) |-> (prdata == DATA_W'(kind_q)))
		else $error("kind register readback mismatch");

	a_input_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid && !m_tready |=> !$isunknown(s_tready))
		else $error("intake ready unknown");

endmodule

bind motor_feedback_angle_tracker mfat_checker u_mfat_checker (.*);
`default_nettype wire
